[hw/rtl/prc_pkg.sv]
// Package with the shared types and constants of the pressure ring conditioner.
`timescale 1ns / 1ps
package prc_pkg;
   localparam int SAMPLE_BITS = 10;
   localparam int CHANNELS    = 8;
   localparam int CH_BITS     = 3;
   localparam int PCT_BITS    = 7;
   localparam int HISTORY     = 4;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [PCT_BITS-1:0]    pct_type;

   typedef struct packed {
      sample_type [CHANNELS-1:0] sample;
   } req_type;

   typedef struct packed {
      pct_type [CHANNELS-1:0] dir;
      logic [CH_BITS-1:0]     strongest_channel;
      pct_type                mean_percent;
      logic                   object_present;
      logic                   object_pressed;
   } rsp_type;

   // Register byte addresses.
   localparam logic [2:0] ADDR_PLACE = 3'd0;
   localparam logic [2:0] ADDR_PRESS = 3'd4;
   localparam pct_type PLACE_RESET = 7'd12;
   localparam pct_type PRESS_RESET = 7'd35;
endpackage

[hw/rtl/prc_stream_if.sv]
// Valid/ready stream interfaces for the request and response channels.
`timescale 1ns / 1ps
interface prc_req_if;
   logic              valid;
   logic              ready;
   prc_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface prc_rsp_if;
   logic              valid;
   logic              ready;
   prc_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/prc_divider.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module prc_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [prc_pkg::SAMPLE_BITS+6:0]  dividend,
   input  logic [prc_pkg::SAMPLE_BITS-1:0]  divisor,
   output logic                             done,
   output logic [prc_pkg::PCT_BITS-1:0]     quotient
);
   localparam int NB = prc_pkg::SAMPLE_BITS + 7;
   localparam int CB = $clog2(NB + 1);

   logic [NB-1:0]                    quo_ff, quo_in;
   logic [prc_pkg::SAMPLE_BITS:0]    rem_ff, rem_in;
   logic [prc_pkg::SAMPLE_BITS-1:0]  dvs_ff, dvs_in;
   logic [CB-1:0]                    cnt_ff, cnt_in;
   logic                             busy_ff, busy_in, done_ff, done_in;
   logic [prc_pkg::SAMPLE_BITS+1:0]  trial;

   // One shift and trial subtract per cycle.
   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; dvs_in = dvs_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, quo_ff[NB-1]} - {2'b00, dvs_ff};
      if (start) begin
         quo_in = dividend; rem_in = '0; dvs_in = divisor;
         cnt_in = CB'(NB); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[prc_pkg::SAMPLE_BITS+1]) begin
            rem_in = trial[prc_pkg::SAMPLE_BITS:0];
            quo_in = {quo_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[prc_pkg::SAMPLE_BITS-1:0], quo_ff[NB-1]};
            quo_in = {quo_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CB'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in; rem_ff <= rem_in; dvs_ff <= dvs_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff[prc_pkg::PCT_BITS-1:0];
endmodule

[hw/rtl/pressure_ring_conditioner.sv]
// Top level of the pressure ring conditioner.
`timescale 1ns / 1ps
// Takes one scan of eight samples per transaction and returns one response.
// Each channel's history, minimum and maximum live in one memory word that is
// read into a register ahead of use, and the channels are handled one after
// another. A channel passes a read state, a smoothing state and a range update
// state. The shared serial divider then needs a start, 17 quotient steps and a
// done, and the divider sets the pace. A ring average state and the response
// register load follow the last channel. A new scan is accepted only in the idle
// state, once the response register has been loaded. After reset a clearing pass
// over the eight channels writes the reset state into the memory; no transaction
// is accepted during it. The response sits in an output register and is held
// until taken. The next scan is accepted and worked on meanwhile; it waits only
// when its own response is ready before the previous one has been taken.
module pressure_ring_conditioner (
   input  logic         clock,
   input  logic         reset,
   prc_req_if.sink      req,
   prc_rsp_if.source    rsp,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   localparam int SB = prc_pkg::SAMPLE_BITS;
   localparam int NCH = prc_pkg::CHANNELS;
   localparam int CB = prc_pkg::CH_BITS;
   localparam int WB = SB * (prc_pkg::HISTORY + 2);
   localparam logic [SB-1:0] SMAX = '1;
   // Scaled reciprocal of twenty; exact for every weighted sum of five samples.
   localparam int SM_SHIFT = SB + 15;
   localparam logic [SB+11:0] SM_RECIP =
      (SB+12)'(((64'd1 << SM_SHIFT) + 64'd19) / 64'd20);
   // Scaled reciprocal of twenty-four; exact for ring sums up to 2400.
   localparam logic [11:0] RING_RECIP = 12'd2731;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_SMOOTH, ST_CALC, ST_DIV, ST_RING, ST_OUT
   } state_type;

   // Configuration registers.
   prc_pkg::pct_type place_ff, press_ff;
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         place_ff <= prc_pkg::PLACE_RESET;
         press_ff <= prc_pkg::PRESS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr == prc_pkg::ADDR_PLACE) place_ff <= csr_pwdata[6:0];
         if (csr_paddr == prc_pkg::ADDR_PRESS) press_ff <= csr_pwdata[6:0];
      end
   end
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == prc_pkg::ADDR_PLACE) csr_prdata = {25'd0, place_ff};
      else if (csr_paddr == prc_pkg::ADDR_PRESS) csr_prdata = {25'd0, press_ff};
   end

   // Channel memory: {max, min, h3, h2, h1, h0}.
   logic [WB-1:0] mem [NCH];
   logic [WB-1:0] rd_ff;
   logic          we;
   logic [CB-1:0] waddr;
   logic [WB-1:0] wdata;
   logic [CB-1:0] ch_ff;
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[ch_ff];
   end

   state_type     state_ff;
   prc_pkg::req_type scan_ff;
   prc_pkg::pct_type pct_ff [NCH];
   prc_pkg::rsp_type rsp_ff;
   logic          rsp_valid_ff;
   logic [SB-1:0] sm_ff, lo_ff, hi_ff;
   logic          zero_ff, div_start_ff;
   logic          div_done;
   prc_pkg::pct_type quo;

   // Smoother from the word just read; the range update uses the registered value.
   logic [SB-1:0]     s, h0, h1, h2, h3, mn, mx, mn_n, mx_n;
   logic [SB+4:0]     wsum;
   logic [2*SB+16:0]  wprod;
   logic [SB-1:0]     sm;
   always_comb begin
      s  = scan_ff.sample[ch_ff];
      h0 = rd_ff[SB-1:0];       h1 = rd_ff[2*SB-1:SB];
      h2 = rd_ff[3*SB-1:2*SB];  h3 = rd_ff[4*SB-1:3*SB];
      mn = rd_ff[5*SB-1:4*SB];  mx = rd_ff[6*SB-1:5*SB];
      wsum = (SB+5)'(s) * (SB+5)'(10) + (SB+5)'(h0) * (SB+5)'(4)
           + (SB+5)'(h1) * (SB+5)'(3) + (SB+5)'(h2) * (SB+5)'(2) + (SB+5)'(h3);
      wprod = (2*SB+17)'(wsum) * (2*SB+17)'(SM_RECIP);
      sm = wprod[SM_SHIFT +: SB];
      mn_n = (sm_ff < mn && sm_ff != '0) ? sm_ff : mn;
      mx_n = (sm_ff > mx) ? sm_ff : mx;
   end

   prc_divider u_div (
      .clock(clock), .reset(reset), .start(div_start_ff),
      .dividend((SB+7)'(sm_ff - lo_ff) * (SB+7)'(100)),
      .divisor(hi_ff - lo_ff), .done(div_done), .quotient(quo)
   );

   // Ring average, peak, mean and the two threshold flags over the stored percentages.
   prc_pkg::rsp_type rsp_n;
   logic [11:0] rsum;
   logic [23:0] rprod;
   logic [9:0]  msum;
   prc_pkg::pct_type peak;
   always_comb begin
      rsp_n = '0; msum = '0; peak = '0; rsum = '0; rprod = '0;
      for (int c = 0; c < NCH; c++) begin
         rsum = 12'(pct_ff[c]) * 12'd10 + 12'(pct_ff[(c + NCH - 1) % NCH]) * 12'd7
              + 12'(pct_ff[(c + 1) % NCH]) * 12'd7;
         rprod = 24'(rsum) * 24'(RING_RECIP);
         rsp_n.dir[c] = rprod[22:16];
         msum = msum + 10'(pct_ff[c]);
         if (pct_ff[c] > peak) peak = pct_ff[c];
      end
      for (int c = 0; c < NCH; c++)
         if (pct_ff[c] == peak) rsp_n.strongest_channel = CB'(c);
      rsp_n.mean_percent   = msum[9:3];
      rsp_n.object_present = msum[9:3] > place_ff;
      rsp_n.object_pressed = msum[9:3] > press_ff;
   end

   always_comb begin
      we = 1'b0; waddr = ch_ff; wdata = {mx_n, mn_n, h2, h1, h0, s};
      if (state_ff == ST_CLEAR) begin
         we = 1'b1; wdata = {{SB{1'b0}}, SMAX, {(4*SB){1'b0}}};
      end else if (state_ff == ST_CALC) we = 1'b1;
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; ch_ff <= '0; rsp_valid_ff <= 1'b0; div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= (state_ff == ST_CALC);
         // The response register refills once it is empty or being taken.
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp.ready)) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               ch_ff <= ch_ff + 1'b1;
               if (ch_ff == CB'(NCH - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: if (req.valid && req.ready) begin
               scan_ff <= req.data; ch_ff <= '0; state_ff <= ST_READ;
            end
            ST_READ: state_ff <= ST_SMOOTH;
            ST_SMOOTH: begin
               sm_ff <= sm;
               state_ff <= ST_CALC;
            end
            ST_CALC: begin
               lo_ff <= mn_n; hi_ff <= mx_n;
               zero_ff <= (mx_n <= mn_n) || (sm_ff < mn_n);
               state_ff <= ST_DIV;
            end
            ST_DIV: if (div_done) begin
               pct_ff[ch_ff] <= zero_ff ? '0 : quo;
               if (ch_ff == CB'(NCH - 1)) state_ff <= ST_RING;
               else begin
                  ch_ff <= ch_ff + 1'b1; state_ff <= ST_READ;
               end
            end
            ST_RING: state_ff <= ST_OUT;
            ST_OUT: if (!rsp_valid_ff || rsp.ready) begin
               rsp_ff <= rsp_n; state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
